### design/fpc_pkg.sv
package fpc_pkg;

   // Angle format: Q9.7 degrees. Internal CORDIC angle: Q.20 degrees.
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int ZF              = 20;
   localparam int ANGLE_SHIFT     = ZF - ANGLE_FRAC_BITS;
   localparam int TURN_SHIFT      = 12 - ANGLE_FRAC_BITS;
   localparam int FULL_TURN       = 360 << ANGLE_FRAC_BITS;
   localparam int HALF_TURN       = FULL_TURN / 2;
   localparam int RIGHT_ANGLE     = 90 << ANGLE_FRAC_BITS;
   localparam int WRAP_STEPS      = 14;
   localparam int ONE14           = 16384;
   localparam int CORDIC_X0       = 652032874;

   localparam logic [15:0] MOUSE_GAIN_RST  = 16'd2458;
   localparam logic [13:0] PITCH_LIMIT_RST = 14'd11392;
   localparam logic [15:0] MOVE_STEP_RST   = 16'd3277;
   localparam logic [15:0] ARROW_STEP_RST  = 16'd3277;

   typedef enum logic [1:0] {
      OP_POINTER = 2'd0,
      OP_KEYS    = 2'd1,
      OP_ARROW   = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ARROW_UP    = 2'd0,
      ARROW_DOWN  = 2'd1,
      ARROW_LEFT  = 2'd2,
      ARROW_RIGHT = 2'd3
   } arrow_type;

   typedef enum logic [1:0] {
      CSR_MOUSE_GAIN  = 2'd0,
      CSR_PITCH_LIMIT = 2'd1,
      CSR_MOVE_STEP   = 2'd2,
      CSR_ARROW_STEP  = 2'd3
   } csr_index_type;

   // atan(2^-i) in Q.20 degrees
   function automatic logic [26:0] atan_q20(input logic [4:0] i);
      logic [26:0] v;
      case (i)
         5'd0:    v = 27'd47185920;
         5'd1:    v = 27'd27855475;
         5'd2:    v = 27'd14718068;
         5'd3:    v = 27'd7471121;
         5'd4:    v = 27'd3750058;
         5'd5:    v = 27'd1876857;
         5'd6:    v = 27'd938658;
         5'd7:    v = 27'd469357;
         5'd8:    v = 27'd234682;
         5'd9:    v = 27'd117342;
         5'd10:   v = 27'd58671;
         5'd11:   v = 27'd29335;
         5'd12:   v = 27'd14668;
         5'd13:   v = 27'd7334;
         5'd14:   v = 27'd3667;
         5'd15:   v = 27'd1833;
         5'd16:   v = 27'd917;
         5'd17:   v = 27'd458;
         5'd18:   v = 27'd229;
         5'd19:   v = 27'd115;
         5'd20:   v = 27'd57;
         5'd21:   v = 27'd29;
         5'd22:   v = 27'd14;
         5'd23:   v = 27'd7;
         default: v = 27'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sd2147483647)       r = 32'sh7FFFFFFF;
      else if (v < -33'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

   // Q2.30 -> Q1.14, round half up, clamp, optional negate
   function automatic logic signed [15:0] trig_out(input logic signed [33:0] v,
                                                   input logic flip);
      logic signed [33:0] t;
      logic signed [15:0] c;
      t = (v + 34'sd32768) >>> 16;
      if (t > 34'sd16384)       c = 16'sd16384;
      else if (t < -34'sd16384) c = -16'sd16384;
      else                      c = t[15:0];
      return flip ? -c : c;
   endfunction

   // -1/0/+1 times v from a pair of opposing keys
   function automatic logic signed [17:0] key_term(input logic pos, input logic neg,
                                                   input logic signed [15:0] v);
      logic signed [17:0] r;
      if (pos && !neg)      r = 18'(v);
      else if (neg && !pos) r = -18'(v);
      else                  r = '0;
      return r;
   endfunction

endpackage

### design/fpc_if.sv
interface fpc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [15:0] pointer_x;
   logic signed [15:0] pointer_y;
   logic [5:0]         key_mask;
   logic [1:0]         arrow_code;

   modport source (output valid, opcode, pointer_x, pointer_y, key_mask, arrow_code,
                   input ready);
   modport sink   (input valid, opcode, pointer_x, pointer_y, key_mask, arrow_code,
                   output ready);
endinterface

interface fpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] position_x;
   logic signed [31:0] position_y;
   logic signed [31:0] position_z;
   logic [15:0]        yaw_out;
   logic signed [14:0] pitch_out;
   logic signed [15:0] look_x;
   logic signed [15:0] look_y;
   logic signed [15:0] look_z;

   modport source (output valid, position_x, position_y, position_z, yaw_out, pitch_out,
                   look_x, look_y, look_z, input ready);
   modport sink   (input valid, position_x, position_y, position_z, yaw_out, pitch_out,
                   look_x, look_y, look_z, output ready);
endinterface

### design/first_person_camera_update_top.sv
// First-person yaw/pitch camera, one event per item.
// req (sink): opcode, pointer_x/y, key_mask, arrow_code. Accepted when
//   valid and ready are high at a rising clock edge. ready is high only
//   while the sequencer is idle; one item is in work at a time.
// rsp (source): position, yaw, pitch and forward vector after the event,
//   exactly one item per request. The result sits in an output register;
//   a new request is taken while it waits, but the finished next result
//   holds in the sequencer until the receiver has taken the previous one.
// csr: csr_we/csr_index/csr_wdata write gain, pitch limit, move and
//   arrow steps; write only while idle.
// Steps: a pointer move with a prior pointer runs the mouse turn, the
//   yaw modulo, both CORDIC passes, the vector steps and the result write;
//   a movement key tick runs the CORDIC passes, the vector steps, the
//   position steps and the result write; others skip turn, modulo and
//   position steps. The time is set by the shared CORDIC, run once for
//   yaw and once for pitch, the 14-step modulo of yaw and the single
//   shared 18x18 multiplier. The next item is accepted once the previous
//   result has moved into the rsp register; items never overlap.
// Reset (synchronous, active high): position and angles zero, no pointer
//   seen, registers to their defaults, rsp empty.
module first_person_camera_update_top #(
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   fpc_req_if.sink     req,
   fpc_rsp_if.source   rsp
);
   import fpc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_TURN = 6'b000010,
      ST_WRAP = 6'b000100,
      ST_CORD = 6'b001000,
      ST_VEC  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   localparam logic signed [31:0] WRAP_BIAS = 32'(FULL_TURN << (WRAP_STEPS - 1));

   // configuration
   logic [15:0] mouse_gain_ff, move_step_ff, arrow_step_ff;
   logic [13:0] pitch_limit_ff;

   // sequencer
   state_type   state_ff, state_in;
   logic [3:0]  mstep_ff, mstep_in;
   logic [3:0]  wrap_k_ff, wrap_k_in;
   logic [29:0] wrap_ff, wrap_in;
   logic        phase_ff, phase_in;
   logic        start_ff, start_in;
   logic [1:0]  op_ff, op_in;
   logic [5:0]  keys_ff, keys_in;

   // camera state
   logic signed [15:0] px_ff, px_in, py_ff, py_in;
   logic signed [15:0] lastx_ff, lastx_in, lasty_ff, lasty_in;
   logic               seen_ff, seen_in;
   logic [15:0]        yaw_ff, yaw_in;
   logic signed [14:0] pitch_ff, pitch_in;
   logic signed [31:0] posx_ff, posx_in, posy_ff, posy_in, posz_ff, posz_in;

   // vectors
   logic signed [15:0] sy_ff, sy_in, cy_ff, cy_in, sp_ff, sp_in, cp_ff, cp_in;
   logic signed [15:0] f0_ff, f0_in, f2_ff, f2_in;
   logic signed [15:0] u0_ff, u0_in, u1_ff, u1_in, u2_ff, u2_in;
   logic signed [35:0] acc_ff, acc_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rpx_ff, rpx_in, rpy_ff, rpy_in, rpz_ff, rpz_in;
   logic [15:0]        ryaw_ff, ryaw_in;
   logic signed [14:0] rpitch_ff, rpitch_in;
   logic signed [15:0] rlx_ff, rlx_in, rly_ff, rly_in, rlz_ff, rlz_in;

   // datapath
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] prod, rnd14, rnd5;
   logic signed [36:0] u1_sum, u1_rnd;
   logic signed [31:0] yaw_sum, pitch_sum, lim32;
   logic [14:0]        lim15;
   logic [29:0]        wrap_sub, wrap_next;
   logic signed [17:0] sx, sy_sum, sz;
   logic signed [15:0] cord_angle, cord_sin, cord_cos, yaw_signed;
   logic               cord_done, accept, rsp_take;

   fpc_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .angle (cord_angle),
      .done  (cord_done),
      .sin_q (cord_sin),
      .cos_q (cord_cos)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign rsp_take  = rsp_valid_ff && rsp.ready;

   // yaw folded to -180..180 for the sine/cosine
   assign yaw_signed = (yaw_ff >= 16'(HALF_TURN)) ? signed'(yaw_ff - 16'(FULL_TURN))
                                                   : signed'(yaw_ff);
   assign cord_angle = phase_ff ? 16'(pitch_ff) : yaw_signed;

   // net key directions times the vectors, per axis
   always_comb begin
      sx     = key_term(keys_ff[0], keys_ff[1], f0_ff) + key_term(keys_ff[3], keys_ff[2], -cy_ff)
             + key_term(keys_ff[5], keys_ff[4], u0_ff);
      sy_sum = key_term(keys_ff[0], keys_ff[1], sp_ff) + key_term(keys_ff[5], keys_ff[4], u1_ff);
      sz     = key_term(keys_ff[0], keys_ff[1], f2_ff) + key_term(keys_ff[3], keys_ff[2], sy_ff)
             + key_term(keys_ff[5], keys_ff[4], u2_ff);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_TURN) begin
         mul_a = (mstep_ff == 4'd0) ? 18'(17'(px_ff) - 17'(lastx_ff))
                                    : 18'(17'(py_ff) - 17'(lasty_ff));
         mul_b = 18'({2'b00, mouse_gain_ff});
      end else if (state_ff == ST_VEC) begin
         case (mstep_ff)
            4'd0:    begin mul_a = 18'(cp_ff); mul_b = 18'(sy_ff); end
            4'd1:    begin mul_a = 18'(cp_ff); mul_b = 18'(cy_ff); end
            4'd2:    begin mul_a = 18'(sp_ff); mul_b = 18'(sy_ff); end
            4'd3:    begin mul_a = 18'(sp_ff); mul_b = 18'(cy_ff); end
            4'd4:    begin mul_a = 18'(f2_ff); mul_b = 18'(cy_ff); end
            4'd5:    begin mul_a = 18'(f0_ff); mul_b = 18'(sy_ff); end
            4'd6:    begin mul_a = sx;         mul_b = 18'({2'b00, move_step_ff}); end
            4'd7:    begin mul_a = sy_sum;     mul_b = 18'({2'b00, move_step_ff}); end
            4'd8:    begin mul_a = sz;         mul_b = 18'({2'b00, move_step_ff}); end
            default: begin mul_a = '0;         mul_b = '0; end
         endcase
      end
   end

   assign prod   = mul_a * mul_b;
   assign rnd14  = (prod + 36'sd8192) >>> 14;
   assign rnd5   = (prod + 36'(1 << (TURN_SHIFT - 1))) >>> TURN_SHIFT;
   assign u1_sum = -37'(acc_ff) - 37'(prod);
   assign u1_rnd = (u1_sum + 37'sd8192) >>> 14;

   assign yaw_sum   = 32'(signed'({1'b0, yaw_ff})) + 32'(rnd5) + WRAP_BIAS;
   assign pitch_sum = 32'(pitch_ff) - 32'(rnd5);
   assign lim15     = ({1'b0, pitch_limit_ff} > 15'(RIGHT_ANGLE)) ? 15'(RIGHT_ANGLE)
                                                                  : {1'b0, pitch_limit_ff};
   assign lim32     = 32'(signed'({1'b0, lim15}));
   assign wrap_sub  = 30'(FULL_TURN) << wrap_k_ff;
   assign wrap_next = (wrap_ff >= wrap_sub) ? wrap_ff - wrap_sub : wrap_ff;

   always_comb begin
      state_in  = state_ff;
      mstep_in  = mstep_ff;
      wrap_k_in = wrap_k_ff;
      wrap_in   = wrap_ff;
      phase_in  = phase_ff;
      start_in  = 1'b0;
      op_in     = op_ff;
      keys_in   = keys_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      lastx_in  = lastx_ff;
      lasty_in  = lasty_ff;
      seen_in   = seen_ff;
      yaw_in    = yaw_ff;
      pitch_in  = pitch_ff;
      posx_in   = posx_ff;
      posy_in   = posy_ff;
      posz_in   = posz_ff;
      sy_in = sy_ff; cy_in = cy_ff; sp_in = sp_ff; cp_in = cp_ff;
      f0_in = f0_ff; f2_in = f2_ff;
      u0_in = u0_ff; u1_in = u1_ff; u2_in = u2_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      rpx_in = rpx_ff; rpy_in = rpy_ff; rpz_in = rpz_ff;
      ryaw_in = ryaw_ff; rpitch_in = rpitch_ff;
      rlx_in = rlx_ff; rly_in = rly_ff; rlz_in = rlz_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req.opcode;
               keys_in  = req.key_mask;
               px_in    = req.pointer_x;
               py_in    = req.pointer_y;
               mstep_in = '0;
               phase_in = 1'b0;
               if (req.opcode == OP_POINTER && seen_ff) begin
                  state_in = ST_TURN;
               end else begin
                  state_in = ST_CORD;
                  start_in = 1'b1;
                  if (req.opcode == OP_POINTER) begin
                     seen_in  = 1'b1;
                     lastx_in = req.pointer_x;
                     lasty_in = req.pointer_y;
                  end else if (req.opcode == OP_ARROW) begin
                     case (req.arrow_code)
                        ARROW_UP: posy_in = sat32(33'(posy_ff)
                                        + 33'(signed'({1'b0, arrow_step_ff})));
                        ARROW_DOWN: posy_in = sat32(33'(posy_ff)
                                        - 33'(signed'({1'b0, arrow_step_ff})));
                        ARROW_LEFT: posx_in = sat32(33'(posx_ff)
                                        - 33'(signed'({1'b0, arrow_step_ff})));
                        default: posx_in = sat32(33'(posx_ff)
                                        + 33'(signed'({1'b0, arrow_step_ff})));
                     endcase
                  end
               end
            end
         end
         ST_TURN: begin
            if (mstep_ff == 4'd0) begin
               wrap_in   = 30'(yaw_sum);
               wrap_k_in = 4'(WRAP_STEPS - 1);
               mstep_in  = 4'd1;
            end else begin
               if (pitch_sum > lim32)       pitch_in = lim15;
               else if (pitch_sum < -lim32) pitch_in = -lim15;
               else                         pitch_in = pitch_sum[14:0];
               lastx_in = px_ff;
               lasty_in = py_ff;
               mstep_in = '0;
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            wrap_in = wrap_next;
            if (wrap_k_ff == 4'd0) begin
               yaw_in   = wrap_next[15:0];
               state_in = ST_CORD;
               start_in = 1'b1;
            end else begin
               wrap_k_in = wrap_k_ff - 1'b1;
            end
         end
         ST_CORD: begin
            if (cord_done) begin
               if (!phase_ff) begin
                  sy_in    = cord_sin;
                  cy_in    = cord_cos;
                  phase_in = 1'b1;
                  start_in = 1'b1;
               end else begin
                  sp_in    = cord_sin;
                  cp_in    = cord_cos;
                  mstep_in = '0;
                  state_in = ST_VEC;
               end
            end
         end
         ST_VEC: begin
            mstep_in = mstep_ff + 1'b1;
            case (mstep_ff)
               4'd0: f0_in = rnd14[15:0];
               4'd1: f2_in = rnd14[15:0];
               4'd2: u0_in = rnd14[15:0];
               4'd3: u2_in = rnd14[15:0];
               4'd4: acc_in = prod;
               4'd5: begin
                  u1_in = u1_rnd[15:0];
                  if (op_ff != OP_KEYS) state_in = ST_FIN;
               end
               4'd6: posx_in = sat32(33'(posx_ff) + 33'(rnd14));
               4'd7: posy_in = sat32(33'(posy_ff) + 33'(rnd14));
               4'd8: begin
                  posz_in  = sat32(33'(posz_ff) + 33'(rnd14));
                  state_in = ST_FIN;
               end
               default: state_in = ST_FIN;
            endcase
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rpx_in    = posx_ff;
               rpy_in    = posy_ff;
               rpz_in    = posz_ff;
               ryaw_in   = yaw_ff;
               rpitch_in = pitch_ff;
               rlx_in    = f0_ff;
               rly_in    = sp_ff;
               rlz_in    = f2_ff;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         seen_ff        <= 1'b0;
         lastx_ff       <= '0;
         lasty_ff       <= '0;
         yaw_ff         <= '0;
         pitch_ff       <= '0;
         posx_ff        <= '0;
         posy_ff        <= '0;
         posz_ff        <= '0;
         mouse_gain_ff  <= MOUSE_GAIN_RST;
         pitch_limit_ff <= PITCH_LIMIT_RST;
         move_step_ff   <= MOVE_STEP_RST;
         arrow_step_ff  <= ARROW_STEP_RST;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         lastx_ff     <= lastx_in;
         lasty_ff     <= lasty_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         posx_ff      <= posx_in;
         posy_ff      <= posy_in;
         posz_ff      <= posz_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MOUSE_GAIN:  mouse_gain_ff  <= csr_wdata;
               CSR_PITCH_LIMIT: pitch_limit_ff <= csr_wdata[13:0];
               CSR_MOVE_STEP:   move_step_ff   <= csr_wdata;
               default:         arrow_step_ff  <= csr_wdata;
            endcase
         end
      end
      mstep_ff  <= mstep_in;
      wrap_k_ff <= wrap_k_in;
      wrap_ff   <= wrap_in;
      phase_ff  <= phase_in;
      op_ff     <= op_in;
      keys_ff   <= keys_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      sy_ff <= sy_in; cy_ff <= cy_in; sp_ff <= sp_in; cp_ff <= cp_in;
      f0_ff <= f0_in; f2_ff <= f2_in;
      u0_ff <= u0_in; u1_ff <= u1_in; u2_ff <= u2_in;
      acc_ff <= acc_in;
      rpx_ff <= rpx_in; rpy_ff <= rpy_in; rpz_ff <= rpz_in;
      ryaw_ff <= ryaw_in; rpitch_ff <= rpitch_in;
      rlx_ff <= rlx_in; rly_ff <= rly_in; rlz_ff <= rlz_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.position_x = rpx_ff;
   assign rsp.position_y = rpy_ff;
   assign rsp.position_z = rpz_ff;
   assign rsp.yaw_out    = ryaw_ff;
   assign rsp.pitch_out  = rpitch_ff;
   assign rsp.look_x     = rlx_ff;
   assign rsp.look_y     = rly_ff;
   assign rsp.look_z     = rlz_ff;

endmodule

### design/fpc_cordic.sv
module fpc_cordic #(
   parameter int ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] angle,
   output logic               done,
   output logic signed [15:0] sin_q,
   output logic signed [15:0] cos_q
);
   import fpc_pkg::*;

   localparam int ITER_W = $clog2(ITERATIONS);
   localparam logic signed [29:0] QUARTER = 30'(90 <<< ZF);
   localparam logic signed [29:0] HALF    = 30'(180 <<< ZF);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               flip_ff, flip_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [29:0] z_ff, z_in;

   logic signed [29:0] z_raw;
   logic signed [33:0] dx, dy;
   logic signed [29:0] at;

   always_comb begin
      z_raw = 30'(angle) <<< ANGLE_SHIFT;
      dx    = y_ff >>> iter_ff;
      dy    = x_ff >>> iter_ff;
      at    = 30'(atan_q20(5'(iter_ff)));
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         x_in    = 34'(CORDIC_X0);
         y_in    = '0;
         if (z_raw > QUARTER) begin
            z_in = z_raw - HALF;
            flip_in = 1'b1;
         end else if (z_raw < -QUARTER) begin
            z_in = z_raw + HALF;
            flip_in = 1'b1;
         end else begin
            z_in = z_raw;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         if (iter_ff == ITER_W'(ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            iter_in = iter_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in;
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done  = done_ff;
   assign cos_q = trig_out(x_ff, flip_ff);
   assign sin_q = trig_out(y_ff, flip_ff);

endmodule
